// ----- hdl/sample_voice_mixer_top_assert.svh -----
// ----------------------------------------------------------------------------
// sample_voice_mixer_top_assert.svh
// assertion macros for the sample voice mixer
// ----------------------------------------------------------------------------
`ifndef SAMPLE_VOICE_MIXER_TOP_ASSERT_SVH
`define SAMPLE_VOICE_MIXER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// clocked check, skipped while reset is held
`define SVM_ASSERT(label, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("svm assertion failed");

// clocked check that also runs during reset
`define SVM_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge i_clk) (expr)) \
        else $error("svm assertion failed");

`else

`define SVM_ASSERT(label, expr)
`define SVM_ASSERT_ALWAYS(label, expr)

`endif

`endif

// ----- hdl/svm_pkg.sv -----
// ----------------------------------------------------------------------------
// svm_pkg
// shared types and constants of the sample voice mixer
// ----------------------------------------------------------------------------
package svm_pkg;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_LENGTH  = 2'd1,
        OP_TRIGGER = 2'd2,
        OP_TICK    = 2'd3
    } t_op;

    localparam logic [15:0] GAIN_ONE = 16'h8000;
    localparam logic signed [17:0] OUT_MAX = 18'sd32767;

    // commands from controller to datapath
    typedef struct packed {
        logic accept;
        logic scan_step;
        logic trig_write;
        logic tick_rd;
        logic tick_mac;
        logic emit;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

// ----- hdl/svm_if.sv -----
// ----------------------------------------------------------------------------
// svm_if
// request channels of the sample voice mixer
// ----------------------------------------------------------------------------
interface svm_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [3:0]  sound_id;
    logic [13:0] frame_index;
    logic signed [15:0] left_value;
    logic signed [15:0] right_value;
    logic [14:0] new_length;
    logic [15:0] left_gain;
    logic [15:0] right_gain;

    modport source (output valid, op, sound_id, frame_index, left_value, right_value,
                    new_length, left_gain, right_gain, input ready);
    modport sink   (input valid, op, sound_id, frame_index, left_value, right_value,
                    new_length, left_gain, right_gain, output ready);
endinterface

interface svm_out_if;
    logic        valid;
    logic        ready;
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;

    modport source (output valid, left_out, right_out, input ready);
    modport sink   (input valid, left_out, right_out, output ready);
endinterface

// ----- hdl/svm_ctrl.sv -----
// ----------------------------------------------------------------------------
// svm_ctrl
// sequencer of the sample voice mixer: voice walks for trigger and tick
// ----------------------------------------------------------------------------
`include "sample_voice_mixer_top_assert.svh"

module svm_ctrl #(
    parameter int NUM_VOICES = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [1:0]    i_op,
    output logic          o_in_ready,
    input  svm_pkg::t_sts i_sts,
    output svm_pkg::t_cmd o_cmd,
    output logic [((NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1)-1:0] o_idx
);

    localparam int VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam logic [VW-1:0] LAST = VW'(NUM_VOICES - 1);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_SCAN = 6'b000010,
        ST_TRIG = 6'b000100,
        ST_RD   = 6'b001000,
        ST_MAC  = 6'b010000,
        ST_EMIT = 6'b100000
    } t_state;

    t_state        r_state, n_state;
    logic [VW-1:0] r_idx, n_idx;
    logic          w_accept;
    logic          w_last;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_last     = (r_idx == LAST);
    assign o_idx      = r_idx;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        o_cmd   = '0;
        o_cmd.accept = w_accept;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_idx = '0;
                    if (svm_pkg::t_op'(i_op) == svm_pkg::OP_TRIGGER) begin
                        n_state = ST_SCAN;
                    end else if (svm_pkg::t_op'(i_op) == svm_pkg::OP_TICK) begin
                        n_state = ST_RD;
                    end
                end
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (w_last) begin
                    n_state = ST_TRIG;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_TRIG: begin
                o_cmd.trig_write = 1'b1;
                n_state = ST_IDLE;
            end
            ST_RD: begin
                o_cmd.tick_rd = 1'b1;
                n_state = ST_MAC;
            end
            ST_MAC: begin
                o_cmd.tick_mac = 1'b1;
                if (w_last) begin
                    n_state = ST_EMIT;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = ST_RD;
                end
            end
            ST_EMIT: begin
                // wait until the previous frame has left the output register
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    `SVM_ASSERT(a_emit_free, o_cmd.emit |-> i_sts.out_free)
    `SVM_ASSERT(a_rd_then_mac, o_cmd.tick_rd |=> o_cmd.tick_mac && $stable(r_idx))
    `SVM_ASSERT(a_walk_starts_at_zero, $rose(o_cmd.scan_step) |-> (r_idx == '0))
    `SVM_ASSERT(a_one_command, $onehot0({o_cmd.scan_step, o_cmd.trig_write, o_cmd.tick_rd, o_cmd.tick_mac, o_cmd.emit}))
    `SVM_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> o_in_ready)

endmodule

// ----- hdl/svm_datapath.sv -----
// ----------------------------------------------------------------------------
// svm_datapath
// voice table, sound lengths, sample store and stereo mix accumulator
// ----------------------------------------------------------------------------
module svm_datapath #(
    parameter int NUM_VOICES       = 16,
    parameter int NUM_SOUNDS       = 12,
    parameter int FRAMES_PER_SOUND = 16384
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  svm_pkg::t_cmd i_cmd,
    input  logic [((NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1)-1:0] i_idx,
    input  logic [1:0]    i_op,
    input  logic [3:0]    i_sound_id,
    input  logic [13:0]   i_frame_index,
    input  logic signed [15:0] i_left_value,
    input  logic signed [15:0] i_right_value,
    input  logic [14:0]   i_new_length,
    input  logic [15:0]   i_left_gain,
    input  logic [15:0]   i_right_gain,
    input  logic          i_out_ready,
    output svm_pkg::t_sts o_sts,
    output logic          o_out_valid,
    output logic signed [15:0] o_left_out,
    output logic signed [15:0] o_right_out
);

    localparam int VW    = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam int SW    = (NUM_SOUNDS > 1) ? $clog2(NUM_SOUNDS) : 1;
    localparam int PW    = $clog2(FRAMES_PER_SOUND + 1);
    localparam int DEPTH = NUM_SOUNDS * FRAMES_PER_SOUND;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] FRAMES_A = AW'(FRAMES_PER_SOUND);
    localparam logic [PW-1:0] FRAMES_P = PW'(FRAMES_PER_SOUND);

    // voice table
    logic          r_active [NUM_VOICES];
    logic [3:0]    r_vsnd   [NUM_VOICES];
    logic [PW-1:0] r_vpos   [NUM_VOICES];
    logic [15:0]   r_vlg    [NUM_VOICES];
    logic [15:0]   r_vrg    [NUM_VOICES];
    logic [PW-1:0] r_len    [NUM_SOUNDS];
    logic [31:0]   r_mem    [DEPTH];

    // latched trigger request
    logic [3:0]    r_snd;
    logic [15:0]   r_lg, r_rg;

    // trigger scan
    logic          r_found;
    logic [VW-1:0] r_idle_slot, r_steal_slot;
    logic [PW-1:0] r_best;

    // tick voice being mixed
    logic          r_cur_act, r_cur_sok;
    logic [PW-1:0] r_cur_pos, r_cur_len;
    logic [15:0]   r_cur_lg, r_cur_rg;
    logic [31:0]   r_rdata;
    logic signed [15:0] r_accl, r_accr;

    logic          r_out_valid;
    logic signed [15:0] r_left, r_right;

    logic          w_in_sok, w_frame_ok, w_r_sok, w_v_sok, w_rd_ok, w_play, w_trig_ok;
    logic [AW-1:0] w_wr_addr, w_rd_addr;
    logic [3:0]    w_vsnd;
    logic [PW-1:0] w_vpos, w_len_q, w_new_len, w_newpos;
    logic [SW-1:0] w_len_idx;
    logic [VW-1:0] w_slot;
    logic signed [32:0] w_pl, w_pr;
    logic signed [17:0] w_suml, w_sumr;
    logic signed [15:0] w_satl, w_satr;

    assign w_in_sok   = 32'(i_sound_id) < NUM_SOUNDS;
    assign w_frame_ok = 32'(i_frame_index) < FRAMES_PER_SOUND;
    assign w_r_sok    = 32'(r_snd) < NUM_SOUNDS;
    assign w_wr_addr  = AW'(i_sound_id) * FRAMES_A + AW'(i_frame_index);
    assign w_new_len  = (32'(i_new_length) > FRAMES_PER_SOUND) ? FRAMES_P
                                                               : PW'(i_new_length);

    assign w_vsnd    = r_vsnd[i_idx];
    assign w_vpos    = r_vpos[i_idx];
    assign w_v_sok   = 32'(w_vsnd) < NUM_SOUNDS;
    // one read port on the length table, shared by trigger and tick
    assign w_len_idx = i_cmd.trig_write ? r_snd[SW-1:0] : w_vsnd[SW-1:0];
    assign w_len_q   = r_len[w_len_idx];
    assign w_rd_ok   = w_v_sok && (w_vpos < w_len_q);
    assign w_rd_addr = w_rd_ok ? (AW'(w_vsnd) * FRAMES_A + AW'(w_vpos)) : '0;
    assign w_trig_ok = w_r_sok && (w_len_q != '0);
    assign w_slot    = r_found ? r_idle_slot : r_steal_slot;

    // floor(sample * gain / 32768) is an arithmetic shift of the product
    assign w_pl   = $signed(r_rdata[15:0])  * $signed({1'b0, r_cur_lg});
    assign w_pr   = $signed(r_rdata[31:16]) * $signed({1'b0, r_cur_rg});
    assign w_suml = {{2{r_accl[15]}}, r_accl} + w_pl[32:15];
    assign w_sumr = {{2{r_accr[15]}}, r_accr} + w_pr[32:15];

    always_comb begin
        if (w_suml > svm_pkg::OUT_MAX) begin
            w_satl = 16'(svm_pkg::OUT_MAX);
        end else if (w_suml < -svm_pkg::OUT_MAX) begin
            w_satl = 16'(-svm_pkg::OUT_MAX);
        end else begin
            w_satl = w_suml[15:0];
        end
        if (w_sumr > svm_pkg::OUT_MAX) begin
            w_satr = 16'(svm_pkg::OUT_MAX);
        end else if (w_sumr < -svm_pkg::OUT_MAX) begin
            w_satr = 16'(-svm_pkg::OUT_MAX);
        end else begin
            w_satr = w_sumr[15:0];
        end
    end

    assign w_play   = r_cur_sok && (r_cur_pos < r_cur_len);
    assign w_newpos = r_cur_pos + 1'b1;

    // sample store
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && (svm_pkg::t_op'(i_op) == svm_pkg::OP_LOAD)
                && w_in_sok && w_frame_ok) begin
            r_mem[w_wr_addr] <= {i_right_value, i_left_value};
        end
        if (i_cmd.tick_rd) begin
            r_rdata <= r_mem[w_rd_addr];
        end
    end

    // sound lengths
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_SOUNDS; s++) begin
                r_len[s] <= '0;
            end
        end else if (i_cmd.accept && (svm_pkg::t_op'(i_op) == svm_pkg::OP_LENGTH)
                && w_in_sok) begin
            r_len[i_sound_id[SW-1:0]] <= w_new_len;
        end
    end

    // voice table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int v = 0; v < NUM_VOICES; v++) begin
                r_active[v] <= 1'b0;
            end
        end else if (i_cmd.trig_write && w_trig_ok) begin
            r_active[w_slot] <= 1'b1;
        end else if (i_cmd.tick_mac && r_cur_act) begin
            if (!w_play || (w_newpos >= r_cur_len)) begin
                r_active[i_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.trig_write && w_trig_ok) begin
            r_vsnd[w_slot] <= r_snd;
            r_vpos[w_slot] <= '0;
            r_vlg[w_slot]  <= r_lg;
            r_vrg[w_slot]  <= r_rg;
        end else if (i_cmd.tick_mac && r_cur_act && w_play) begin
            r_vpos[i_idx] <= w_newpos;
        end
    end

    // request latch, scan and mix
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_snd   <= i_sound_id;
            r_lg    <= (i_left_gain > svm_pkg::GAIN_ONE) ? svm_pkg::GAIN_ONE : i_left_gain;
            r_rg    <= (i_right_gain > svm_pkg::GAIN_ONE) ? svm_pkg::GAIN_ONE : i_right_gain;
            r_found <= 1'b0;
            r_accl  <= '0;
            r_accr  <= '0;
        end
        if (i_cmd.scan_step) begin
            if (!r_found && !r_active[i_idx]) begin
                r_found     <= 1'b1;
                r_idle_slot <= i_idx;
            end
            if ((i_idx == '0) || (w_vpos > r_best)) begin
                r_best       <= w_vpos;
                r_steal_slot <= i_idx;
            end
        end
        if (i_cmd.tick_rd) begin
            r_cur_act <= r_active[i_idx];
            r_cur_sok <= w_v_sok;
            r_cur_pos <= w_vpos;
            r_cur_len <= w_len_q;
            r_cur_lg  <= r_vlg[i_idx];
            r_cur_rg  <= r_vrg[i_idx];
        end
        if (i_cmd.tick_mac && r_cur_act && w_play) begin
            r_accl <= w_satl;
            r_accr <= w_satr;
        end
        if (i_cmd.emit) begin
            r_left  <= r_accl;
            r_right <= r_accr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_left_out     = r_left;
    assign o_right_out    = r_right;

endmodule

// ----- hdl/sample_voice_mixer_top.sv -----
// ----------------------------------------------------------------------------
// sample_voice_mixer_top
// stereo sample playback mixer with voice stealing
//
//   channel  dir  handshake      payload
//   i_in     in   valid/ready    op, sound_id, frame_index, left/right_value,
//                                new_length, left/right_gain
//   o_out    out  valid/ready    left_out, right_out (op 3 only)
//
// load and length requests are done when accepted; a trigger scans the voices
// in order for a slot, then writes that slot; a tick walks the voices in turn,
// each with a registered read of the sample store followed by the multiply
// and saturating add.
// one request is in work at a time; a finished frame waits in the output
// register, and a following tick holds before its emit until it is taken.
// synchronous active-low reset clears voices and sound lengths at once.
// ----------------------------------------------------------------------------
module sample_voice_mixer_top #(
    parameter int NUM_VOICES       = 16,
    parameter int NUM_SOUNDS       = 12,
    parameter int FRAMES_PER_SOUND = 16384
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    svm_in_if.sink     i_in,
    svm_out_if.source  o_out
);

    localparam int VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

    svm_pkg::t_cmd w_cmd;
    svm_pkg::t_sts w_sts;
    logic [VW-1:0] w_idx;

    svm_ctrl #(
        .NUM_VOICES (NUM_VOICES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_op       (i_in.op),
        .o_in_ready (i_in.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_idx      (w_idx)
    );

    svm_datapath #(
        .NUM_VOICES       (NUM_VOICES),
        .NUM_SOUNDS       (NUM_SOUNDS),
        .FRAMES_PER_SOUND (FRAMES_PER_SOUND)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_idx         (w_idx),
        .i_op          (i_in.op),
        .i_sound_id    (i_in.sound_id),
        .i_frame_index (i_in.frame_index),
        .i_left_value  (i_in.left_value),
        .i_right_value (i_in.right_value),
        .i_new_length  (i_in.new_length),
        .i_left_gain   (i_in.left_gain),
        .i_right_gain  (i_in.right_gain),
        .i_out_ready   (o_out.ready),
        .o_sts         (w_sts),
        .o_out_valid   (o_out.valid),
        .o_left_out    (o_out.left_out),
        .o_right_out   (o_out.right_out)
    );

endmodule

// ----- verif/svm_checker.sv -----
// ----------------------------------------------------------------------------
// svm_checker
// predicts the mixed output frames from accepted requests and compares them
// ----------------------------------------------------------------------------
module svm_checker #(
    parameter int NUM_VOICES       = 16,
    parameter int NUM_SOUNDS       = 12,
    parameter int FRAMES_PER_SOUND = 16384
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    svm_in_if      i_in,
    svm_out_if     i_out,
    output int     o_errors,
    output int     o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [15:0] left;
        logic signed [15:0] right;
    } t_frame;

    logic        voice_on    [NUM_VOICES];
    logic [3:0]  voice_snd   [NUM_VOICES];
    int unsigned voice_pos   [NUM_VOICES];
    int unsigned voice_lgain [NUM_VOICES];
    int unsigned voice_rgain [NUM_VOICES];
    int unsigned snd_len     [NUM_SOUNDS];
    logic [31:0] frame_mem   [int unsigned];
    t_frame      frames_due[$];
    int          n_mismatch;
    int          n_due;

    assign o_errors  = n_mismatch;
    assign o_pending = n_due;

    function automatic int scale_q15(int smp, int unsigned g);
        int p;
        p = smp * int'(g);
        if (p >= 0) return p >>> 15;
        return -((-p + 32767) >>> 15);
    endfunction

    function automatic int sat_sum(int a, int b);
        int s;
        s = a + b;
        if (s > 32767) s = 32767;
        if (s < -32767) s = -32767;
        return s;
    endfunction

    task automatic start_voice(int unsigned snd, int unsigned lg, int unsigned rg);
        int slot;
        int unsigned best;
        slot = -1;
        best = 0;
        for (int v = 0; v < NUM_VOICES; v++)
            if (slot < 0 && !voice_on[v]) slot = v;
        if (slot < 0) begin
            for (int v = 0; v < NUM_VOICES; v++)
                if (v == 0 || voice_pos[v] > best) begin
                    best = voice_pos[v];
                    slot = v;
                end
        end
        voice_on[slot]    = 1'b1;
        voice_snd[slot]   = 4'(snd);
        voice_pos[slot]   = 0;
        voice_lgain[slot] = lg > 32768 ? 32768 : lg;
        voice_rgain[slot] = rg > 32768 ? 32768 : rg;
    endtask

    task automatic mix_frame();
        int accl, accr;
        int unsigned s, pos;
        logic [31:0] w;
        t_frame f;
        accl = 0;
        accr = 0;
        for (int v = 0; v < NUM_VOICES; v++) begin
            if (!voice_on[v]) continue;
            s = voice_snd[v];
            if (s >= NUM_SOUNDS) begin
                voice_on[v] = 1'b0;
                continue;
            end
            pos = voice_pos[v];
            if (pos < snd_len[s]) begin
                w = frame_mem.exists(s * FRAMES_PER_SOUND + pos)
                    ? frame_mem[s * FRAMES_PER_SOUND + pos] : 32'd0;
                accl = sat_sum(accl, scale_q15(int'($signed(w[15:0])), voice_lgain[v]));
                accr = sat_sum(accr, scale_q15(int'($signed(w[31:16])), voice_rgain[v]));
                pos++;
                voice_pos[v] = pos;
            end
            if (pos >= snd_len[s]) voice_on[v] = 1'b0;
        end
        f.left  = accl[15:0];
        f.right = accr[15:0];
        frames_due.push_back(f);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int v = 0; v < NUM_VOICES; v++) begin
                voice_on[v] = 0; voice_snd[v] = 0; voice_pos[v] = 0;
                voice_lgain[v] = 0; voice_rgain[v] = 0;
            end
            for (int s = 0; s < NUM_SOUNDS; s++) snd_len[s] = 0;
            frames_due.delete();
            n_mismatch = 0;
        end else begin
            if (i_out.valid && i_out.ready) begin
                if (frames_due.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("unexpected output frame %0d/%0d", i_out.left_out,
                                 i_out.right_out);
                end else begin
                    t_frame f;
                    f = frames_due.pop_front();
                    if (f.left !== i_out.left_out || f.right !== i_out.right_out) begin
                        n_mismatch++;
                        if (n_mismatch <= 10)
                            $display("frame mismatch: exp %0d/%0d got %0d/%0d", f.left,
                                     f.right, i_out.left_out, i_out.right_out);
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                case (svm_pkg::t_op'(i_in.op))
                    svm_pkg::OP_LOAD: begin
                        if (i_in.sound_id < NUM_SOUNDS && i_in.frame_index < FRAMES_PER_SOUND)
                            frame_mem[i_in.sound_id * FRAMES_PER_SOUND + i_in.frame_index] =
                                {i_in.right_value, i_in.left_value};
                    end
                    svm_pkg::OP_LENGTH: begin
                        if (i_in.sound_id < NUM_SOUNDS)
                            snd_len[i_in.sound_id] = i_in.new_length > FRAMES_PER_SOUND
                                ? FRAMES_PER_SOUND : i_in.new_length;
                    end
                    svm_pkg::OP_TRIGGER: begin
                        if (i_in.sound_id < NUM_SOUNDS && snd_len[i_in.sound_id] != 0)
                            start_voice(i_in.sound_id, i_in.left_gain, i_in.right_gain);
                    end
                    default: mix_frame();
                endcase
            end
        end
        n_due = frames_due.size();
    end
endmodule

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// drives load, length, trigger and tick requests into the sample voice mixer
// with random gaps and output stalls; svm_checker judges the frames
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FPS       = 16384;
    localparam int MAX_CYCLE = 2000000;
    // short sounds keep every played frame inside the loaded region
    localparam int LOADED    = 24;

    logic i_clk;
    logic i_rst_n;
    int   n_err, n_pend;
    int   cycle;
    logic hold_out;

    svm_in_if  in_ch();
    svm_out_if out_ch();

    sample_voice_mixer_top dut (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .o_out(out_ch));
    svm_checker chk (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .i_out(out_ch),
                     .o_errors(n_err), .o_pending(n_pend));

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        cycle = 0;
        forever begin
            @(posedge i_clk);
            cycle++;
            if (cycle > MAX_CYCLE) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // receiver: random stalls, or a long hold while hold_out is set
    initial begin
        int w;
        out_ch.ready = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_out) begin
                out_ch.ready <= 0;
                repeat (400) @(posedge i_clk);
                hold_out = 0;
            end
            w = (cycle / 20000) % 3 == 1 ? 0 : $urandom_range(0, 16);
            if (w > 0) begin
                out_ch.ready <= 0;
                repeat (w) @(posedge i_clk);
            end
            out_ch.ready <= 1;
            @(posedge i_clk iff out_ch.valid);
        end
    end

    task automatic send(svm_pkg::t_op op, logic [3:0] snd, logic [13:0] fr, logic [15:0] lv,
                        logic [15:0] rv, logic [14:0] len, logic [15:0] lg, logic [15:0] rg,
                        bit no_gap = 0);
        int w;
        w = (no_gap || (cycle / 15000) % 3 == 2) ? 0 : $urandom_range(0, 16);
        if (w > 0) begin
            in_ch.valid <= 0;
            repeat (w) @(posedge i_clk);
        end
        in_ch.valid <= 1;
        in_ch.op <= op; in_ch.sound_id <= snd; in_ch.frame_index <= fr;
        in_ch.left_value <= lv; in_ch.right_value <= rv; in_ch.new_length <= len;
        in_ch.left_gain <= lg; in_ch.right_gain <= rg;
        @(posedge i_clk iff in_ch.ready);
    endtask

    task automatic rnd_item();
        int k;
        logic [3:0] snd;
        k = $urandom_range(0, 99);
        snd = 4'($urandom_range(0, 15));
        if (k < 15)
            send(svm_pkg::OP_LOAD, snd,
                 (k < 3) ? 14'($urandom) : 14'($urandom_range(0, LOADED - 1)),
                 16'($urandom), 16'($urandom), 0, 0, 0);
        else if (k < 25)
            // lengths stay within the loaded frames; bad ids get any value
            send(svm_pkg::OP_LENGTH, snd, 0, 0, 0,
                 snd >= 12 ? 15'($urandom) : 15'($urandom_range(0, LOADED)), 0, 0);
        else if (k < 55)
            send(svm_pkg::OP_TRIGGER, snd, 0, 0, 0, 0,
                 (k < 30) ? 16'($urandom) : 16'($urandom_range(0, 32768)),
                 (k < 30) ? 16'($urandom) : 16'($urandom_range(0, 32768)));
        else
            send(svm_pkg::OP_TICK, snd, 14'($urandom), 16'($urandom), 16'($urandom),
                 15'($urandom), 16'($urandom), 16'($urandom));
    endtask

    initial begin
        hold_out = 0;
        i_rst_n = 0;
        in_ch.valid = 0; in_ch.op = 0; in_ch.sound_id = 0; in_ch.frame_index = 0;
        in_ch.left_value = 0; in_ch.right_value = 0; in_ch.new_length = 0;
        in_ch.left_gain = 0; in_ch.right_gain = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // fill the low frames of every sound so any playback reads written data
        for (int s = 0; s < 12; s++)
            for (int f = 0; f < LOADED; f++)
                send(svm_pkg::OP_LOAD, 4'(s), 14'(f), 16'($urandom), 16'($urandom),
                     0, 0, 0, 1);

        // directed: extremes, bad ids, oversize values, absent sound
        send(svm_pkg::OP_LOAD, 0, 0, 16'h8000, 16'h7fff, 0, 0, 0);
        send(svm_pkg::OP_LOAD, 11, 1, 16'h7fff, 16'h8000, 0, 0, 0);
        send(svm_pkg::OP_LOAD, 15, 2, 16'h1234, 16'h1234, 0, 0, 0);
        send(svm_pkg::OP_LOAD, 3, 14'h3fff, 16'h7fff, 16'h7fff, 0, 0, 0);
        send(svm_pkg::OP_TRIGGER, 2, 0, 0, 0, 0, 16'h8000, 16'h8000);
        send(svm_pkg::OP_LENGTH, 0, 0, 0, 0, 15'h7fff, 0, 0);
        send(svm_pkg::OP_LENGTH, 0, 0, 0, 0, 2, 0, 0);
        send(svm_pkg::OP_LENGTH, 11, 0, 0, 0, 3, 0, 0);
        send(svm_pkg::OP_LENGTH, 14, 0, 0, 0, 5, 0, 0);
        send(svm_pkg::OP_TRIGGER, 0, 0, 0, 0, 0, 16'hffff, 16'h8000);
        send(svm_pkg::OP_TRIGGER, 11, 0, 0, 0, 0, 16'h8000, 16'hffff);
        send(svm_pkg::OP_TRIGGER, 12, 0, 0, 0, 0, 16'h8000, 16'h8000);
        send(svm_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0);
        send(svm_pkg::OP_LENGTH, 11, 0, 0, 0, 1, 0, 0);
        send(svm_pkg::OP_TICK, 15, 14'h3fff, 16'hffff, 16'hffff, 15'h7fff, 16'hffff,
             16'hffff);
        send(svm_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0);
        // fill all voices then steal
        send(svm_pkg::OP_LENGTH, 5, 0, 0, 0, 15'(LOADED), 0, 0);
        for (int i = 0; i < 18; i++) begin
            send(svm_pkg::OP_TRIGGER, 5, 0, 0, 0, 0, 16'h8000, 0);
            if (i % 4 == 0) send(svm_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0);
        end

        // sender pause until all frames have come back
        in_ch.valid <= 0;
        while (n_pend != 0) @(posedge i_clk);

        for (int n = 0; n < 1100; n++) begin
            if (n == 500) hold_out = 1;
            rnd_item();
        end
        in_ch.valid <= 0;

        while (n_pend != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (n_err == 0 && n_pend == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
